### sv/rdg_pkg.sv
// Shared types, widths, register codes and helper functions of the pinhole ray direction generator.
// Depends on nothing; every other file of the block imports it.
package rdg_pkg;

    localparam int COORD_BITS_DEF    = 12;
    localparam int DIR_FRAC_BITS_DEF = 14;

    localparam int COORD_FIELD_W = 12;
    localparam int JIT_W         = 16;
    localparam int DIR_W         = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 60;
    localparam int VEC_W         = 60;
    localparam int COMP_W        = 20;
    localparam int PITCH_W       = 32;
    localparam int CENTER_W      = 14;

    // Internal datapath widths.
    localparam int OFS_W      = 34;   // signed Q.16 sample offset
    localparam int OFS_MAG_W  = 31;
    localparam int PMUL_W     = 47;   // 16 x 31 partial product
    localparam int PLANE_W    = 48;   // magnitude of pitch * offset
    localparam int SHIFT_W    = 5;
    localparam int LEN_BITS_W = 7;
    localparam int PROD_W     = 52;   // 32 x 20 signed product
    localparam int NT_W       = 37;
    localparam int SUM_W      = 53;
    localparam int ABS_W      = 52;
    localparam int NORM_W     = 31;
    localparam int SQR_W      = 62;
    localparam int SQ_IN_W    = 64;
    localparam int LEN_W      = 32;
    localparam int SQ_REM_W   = 35;
    localparam int SQ_STAGES  = 16;
    localparam int DIV_REM_W  = 33;
    localparam int RES_MAX    = 32767;
    localparam int NORM_TOP   = 31;   // normalized magnitudes sit in [2^30, 2^31)

    localparam logic [OFS_W-1:0] HALF_Q16 = OFS_W'(32768);   // one half in Q.16

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASIS_RIGHT   = 3'd0,
        CFG_BASIS_UP      = 3'd1,
        CFG_BASIS_FORWARD = 3'd2,
        CFG_PIXEL_PITCH   = 3'd3,
        CFG_HALF_WIDTH    = 3'd4,
        CFG_HALF_HEIGHT   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [COORD_FIELD_W-1:0] pixel_row;
        logic [COORD_FIELD_W-1:0] pixel_col;
        logic [JIT_W-1:0]         jitter_row;
        logic [JIT_W-1:0]         jitter_col;
        logic                     last_sample;
    } t_sample;

    typedef struct packed {
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
        logic                    pixel_done;
    } t_ray;

    typedef struct packed {
        logic [VEC_W-1:0]    basis_right;
        logic [VEC_W-1:0]    basis_up;
        logic [VEC_W-1:0]    basis_forward;
        logic [PITCH_W-1:0]  pixel_pitch;
        logic [CENTER_W-1:0] half_width;
        logic [CENTER_W-1:0] half_height;
    } t_cfg;

    typedef struct packed {
        logic [NORM_W-1:0]  x_mag;
        logic [NORM_W-1:0]  y_mag;
        logic               x_neg;
        logic               y_neg;
        logic [SHIFT_W-1:0] scale;
        logic               last;
    } t_plane;

    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
        logic       last;
    } t_side;

    typedef logic [2:0][NORM_W-1:0] t_lanes;

    function automatic logic signed [COMP_W-1:0] comp20(input logic [VEC_W-1:0] p,
                                                        input logic [1:0] k);
        return signed'(p[COMP_W*k +: COMP_W]);
    endfunction

    // Number of significant bits of v (0 for zero).
    function automatic logic [LEN_BITS_W-1:0] bit_len64(input logic [63:0] v);
        logic [LEN_BITS_W-1:0] n;
        n = '0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                n = LEN_BITS_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

### sv/pinhole_ray_direction_gen_core.sv
// Top level of the pinhole ray direction generator: configuration registers, pipeline
// advance control, output register. Depends on rdg_pkg, rdg_plane, rdg_dir, rdg_sqrt, rdg_div.
//
// This core turns one camera sample per clock, unless the pipeline is frozen, into a unit
// ray direction in signed fixed point with DIR_FRAC_BITS fraction bits. It is a fully
// pipelined design that accepts a new transaction on every cycle while not stalled and
// delivers one result per transaction, in order. A sample passes through offset and
// pitch scaling, basis combination and normalization, square root (two root bits per
// stage), numerator setup, the divider stages (two quotient bits per stage) and the
// output register. The whole pipeline advances together; it freezes only while a result
// waits in the output register and the downstream side stalls, and during that time
// o_in_stall is high. Software loads the camera basis, pixel pitch and image centre
// through the write port while no sample is in flight; writes to indexes beyond the six
// defined registers are ignored.
module pinhole_ray_direction_gen_core import rdg_pkg::*; #(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int DIR_FRAC_BITS = DIR_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_sample               i_sample,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_ray                  o_ray,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int QW    = DIR_FRAC_BITS + 1;
    localparam int EXT_W = QW + DIR_W;

    t_cfg r_cfg;

    logic en;

    logic   pl_valid;
    t_plane pl_data;

    logic               dr_valid;
    logic [SQ_IN_W-1:0] dr_q;
    t_lanes             dr_mag;
    t_side              dr_side;

    logic             sq_valid;
    logic [LEN_W-1:0] sq_len;
    t_lanes           sq_mag;
    t_side            sq_side;

    logic                 dv_valid;
    logic [2:0][QW-1:0]   dv_quo;
    t_side                dv_side;

    logic               r_out_valid;
    t_ray               r_ray;
    logic [2:0][DIR_W-1:0] res;

    // Every stage moves forward unless a finished result is held by the consumer.
    assign en         = !r_out_valid || !i_out_stall;
    assign o_in_stall = !en;

    // Configuration registers, reset to the camera-at-rest defaults.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.basis_right   <= '0;
            r_cfg.basis_up      <= '0;
            r_cfg.basis_forward <= '0;
            r_cfg.pixel_pitch   <= PITCH_W'(65536);
            r_cfg.half_width    <= '0;
            r_cfg.half_height   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_BASIS_RIGHT:   r_cfg.basis_right   <= VEC_W'(i_cfg_data);
                CFG_BASIS_UP:      r_cfg.basis_up      <= VEC_W'(i_cfg_data);
                CFG_BASIS_FORWARD: r_cfg.basis_forward <= VEC_W'(i_cfg_data);
                CFG_PIXEL_PITCH:   r_cfg.pixel_pitch   <= PITCH_W'(i_cfg_data);
                CFG_HALF_WIDTH:    r_cfg.half_width    <= CENTER_W'(i_cfg_data);
                CFG_HALF_HEIGHT:   r_cfg.half_height   <= CENTER_W'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    rdg_plane #(
        .COORD_BITS (COORD_BITS)
    ) u_plane (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_in_valid),
        .i_sample (i_sample),
        .i_cfg    (r_cfg),
        .o_valid  (pl_valid),
        .o_plane  (pl_data)
    );

    rdg_dir u_dir (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (pl_valid),
        .i_plane (pl_data),
        .i_cfg   (r_cfg),
        .o_valid (dr_valid),
        .o_q     (dr_q),
        .o_mag   (dr_mag),
        .o_side  (dr_side)
    );

    rdg_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dr_valid),
        .i_q     (dr_q),
        .i_mag   (dr_mag),
        .i_side  (dr_side),
        .o_valid (sq_valid),
        .o_len   (sq_len),
        .o_mag   (sq_mag),
        .o_side  (sq_side)
    );

    rdg_div #(
        .DIR_FRAC_BITS (DIR_FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_len   (sq_len),
        .i_mag   (sq_mag),
        .i_side  (sq_side),
        .o_valid (dv_valid),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    // Saturate wide quotients, restore the sign, and force a zero vector to zero.
    always_comb begin
        logic [EXT_W-1:0] qx;
        logic [DIR_W-1:0] mag;
        for (int k = 0; k < 3; k++) begin
            qx  = EXT_W'(dv_quo[k]);
            mag = (qx > EXT_W'(RES_MAX)) ? DIR_W'(RES_MAX) : qx[DIR_W-1:0];
            res[k] = dv_side.neg[k] ? -mag : mag;
            if (dv_side.zero) begin
                res[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ray.dir_x      <= signed'(res[0]);
            r_ray.dir_y      <= signed'(res[1]);
            r_ray.dir_z      <= signed'(res[2]);
            r_ray.pixel_done <= dv_side.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ray       = r_ray;

endmodule

### sv/rdg_plane.sv
// Front stages: sample offsets, pitch scaling and block scaling of the plane coordinates.
// Depends on rdg_pkg.
module rdg_plane import rdg_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_sample i_sample,
    input  t_cfg    i_cfg,
    output logic    o_valid,
    output t_plane  o_plane
);

    localparam int CW = (COORD_BITS < COORD_FIELD_W) ? COORD_BITS : COORD_FIELD_W;
    localparam logic [COORD_FIELD_W-1:0] CMASK = ~({COORD_FIELD_W{1'b1}} << CW);

    logic signed [OFS_W-1:0] dc, dr;
    logic [COORD_FIELD_W-1:0] row_m, col_m;

    logic                 r1_v, r1_last, r1_nc, r1_nr;
    logic [OFS_MAG_W-1:0] r1_mc, r1_mr;
    logic                 r2_v, r2_last, r2_nc, r2_nr;
    logic [PMUL_W-1:0]    r2_hc, r2_lc, r2_hr, r2_lr;
    logic                 r3_v, r3_last, r3_nc, r3_nr;
    logic [PLANE_W-1:0]   r3_ax, r3_ay;
    logic                 r4_v;
    t_plane               r4_p;

    logic [LEN_BITS_W-1:0] blen;
    t_plane                n4_p;

    always_comb begin
        row_m = i_sample.pixel_row & CMASK;
        col_m = i_sample.pixel_col & CMASK;
        dc = OFS_W'(signed'({1'b0, col_m, 16'h0000}))
           + OFS_W'(signed'({1'b0, i_sample.jitter_col}))
           - signed'(HALF_Q16)
           - OFS_W'(signed'({1'b0, i_cfg.half_width, 15'h0000}));
        dr = OFS_W'(signed'({1'b0, i_cfg.half_height, 15'h0000}))
           - (OFS_W'(signed'({1'b0, row_m, 16'h0000}))
              + OFS_W'(signed'({1'b0, i_sample.jitter_row}))
              - signed'(HALF_Q16));
    end

    always_comb begin
        blen = bit_len64(64'(r3_ax | r3_ay));
        n4_p.scale = (blen > LEN_BITS_W'(NORM_TOP)) ? SHIFT_W'(blen - LEN_BITS_W'(NORM_TOP))
                                                    : '0;
        n4_p.x_mag = NORM_W'(r3_ax >> n4_p.scale);
        n4_p.y_mag = NORM_W'(r3_ay >> n4_p.scale);
        n4_p.x_neg = r3_nc;
        n4_p.y_neg = r3_nr;
        n4_p.last  = r3_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_nc   <= dc[OFS_W-1];
            r1_nr   <= dr[OFS_W-1];
            r1_mc   <= OFS_MAG_W'(dc[OFS_W-1] ? -dc : dc);
            r1_mr   <= OFS_MAG_W'(dr[OFS_W-1] ? -dr : dr);
            r1_last <= i_sample.last_sample;

            r2_hc   <= PMUL_W'(i_cfg.pixel_pitch[31:16]) * PMUL_W'(r1_mc);
            r2_lc   <= PMUL_W'(i_cfg.pixel_pitch[15:0]) * PMUL_W'(r1_mc);
            r2_hr   <= PMUL_W'(i_cfg.pixel_pitch[31:16]) * PMUL_W'(r1_mr);
            r2_lr   <= PMUL_W'(i_cfg.pixel_pitch[15:0]) * PMUL_W'(r1_mr);
            r2_nc   <= r1_nc;
            r2_nr   <= r1_nr;
            r2_last <= r1_last;

            r3_ax   <= PLANE_W'(r2_hc) + PLANE_W'(r2_lc >> 16);
            r3_ay   <= PLANE_W'(r2_hr) + PLANE_W'(r2_lr >> 16);
            r3_nc   <= r2_nc;
            r3_nr   <= r2_nr;
            r3_last <= r2_last;

            r4_p    <= n4_p;
        end
    end

    assign o_valid = r4_v;
    assign o_plane = r4_p;

endmodule

### sv/rdg_dir.sv
// Middle stages: basis combination, magnitude normalization and sum of squares.
// Depends on rdg_pkg.
module rdg_dir import rdg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_plane             i_plane,
    input  t_cfg               i_cfg,
    output logic               o_valid,
    output logic [SQ_IN_W-1:0] o_q,
    output t_lanes             o_mag,
    output t_side              o_side
);

    logic signed [LEN_W-1:0] xs, ys;
    logic signed [PROD_W-1:0] n1_pu [3];
    logic signed [PROD_W-1:0] n1_pv [3];
    logic signed [NT_W-1:0]   n1_nt [3];

    logic                     r1_v, r1_last;
    logic signed [PROD_W-1:0] r1_pu [3];
    logic signed [PROD_W-1:0] r1_pv [3];
    logic signed [NT_W-1:0]   r1_nt [3];
    logic                     r2_v, r2_last;
    logic signed [SUM_W-1:0]  r2_d [3];
    logic                     r3_v, r3_last;
    logic [2:0][ABS_W-1:0]    r3_a;
    logic [2:0]               r3_neg;
    logic                     r4_v, r4_last;
    logic [2:0][ABS_W-1:0]    r4_a;
    logic [ABS_W-1:0]         r4_mx;
    logic [2:0]               r4_neg;
    logic                     r5_v, r5_shr;
    logic [2:0][ABS_W-1:0]    r5_a;
    logic [SHIFT_W-1:0]       r5_amt;
    t_side                    r5_side;
    logic                     r6_v;
    t_lanes                   r6_an;
    t_side                    r6_side;
    logic                     r7_v;
    logic [2:0][SQR_W-1:0]    r7_sq;
    t_lanes                   r7_an;
    t_side                    r7_side;
    logic                     r8_v;
    logic [SQ_IN_W-1:0]       r8_q;
    t_lanes                   r8_an;
    t_side                    r8_side;

    logic [ABS_W-1:0]      m01, mx;
    logic [LEN_BITS_W-1:0] blen;
    t_lanes                n6_an;

    // Plane coordinates times the basis plus the forward vector at the same scale.
    always_comb begin
        logic signed [COMP_W-1:0] nk;
        logic signed [COMP_W:0]   n21;
        logic [COMP_W-1:0]        nmag;
        xs = i_plane.x_neg ? -signed'({1'b0, i_plane.x_mag}) : signed'({1'b0, i_plane.x_mag});
        ys = i_plane.y_neg ? -signed'({1'b0, i_plane.y_mag}) : signed'({1'b0, i_plane.y_mag});
        for (int k = 0; k < 3; k++) begin
            n1_pu[k] = PROD_W'(xs) * PROD_W'(comp20(i_cfg.basis_right, 2'(k)));
            n1_pv[k] = PROD_W'(ys) * PROD_W'(comp20(i_cfg.basis_up, 2'(k)));
            nk       = comp20(i_cfg.basis_forward, 2'(k));
            n21      = (COMP_W + 1)'(nk);
            nmag     = COMP_W'(n21 < 0 ? -n21 : n21);
            if (i_plane.scale <= SHIFT_W'(16)) begin
                n1_nt[k] = NT_W'(nk) <<< (SHIFT_W'(16) - i_plane.scale);
            end else begin
                n1_nt[k] = NT_W'(signed'({1'b0, nmag >> (i_plane.scale - SHIFT_W'(16))}));
                if (nk < 0) begin
                    n1_nt[k] = -n1_nt[k];
                end
            end
        end
    end

    always_comb begin
        m01  = (r3_a[0] > r3_a[1]) ? r3_a[0] : r3_a[1];
        mx   = (m01 > r3_a[2]) ? m01 : r3_a[2];
        blen = bit_len64(64'(r4_mx));
        for (int k = 0; k < 3; k++) begin
            n6_an[k] = r5_shr ? NORM_W'(r5_a[k] >> r5_amt) : NORM_W'(r5_a[k] << r5_amt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
            r8_v <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pu   <= n1_pu;
            r1_pv   <= n1_pv;
            r1_nt   <= n1_nt;
            r1_last <= i_plane.last;

            for (int k = 0; k < 3; k++) begin
                r2_d[k] <= SUM_W'(r1_pu[k]) + SUM_W'(r1_pv[k]) + SUM_W'(r1_nt[k]);
            end
            r2_last <= r1_last;

            for (int k = 0; k < 3; k++) begin
                r3_neg[k] <= r2_d[k] < 0;
                r3_a[k]   <= ABS_W'(r2_d[k] < 0 ? -r2_d[k] : r2_d[k]);
            end
            r3_last <= r2_last;

            r4_a    <= r3_a;
            r4_mx   <= mx;
            r4_neg  <= r3_neg;
            r4_last <= r3_last;

            // Largest magnitude is brought into [2^30, 2^31).
            r5_a         <= r4_a;
            r5_shr       <= blen > LEN_BITS_W'(NORM_TOP);
            r5_amt       <= (blen > LEN_BITS_W'(NORM_TOP))
                            ? SHIFT_W'(blen - LEN_BITS_W'(NORM_TOP))
                            : SHIFT_W'(LEN_BITS_W'(NORM_TOP) - blen);
            r5_side.neg  <= r4_neg;
            r5_side.zero <= blen == '0;
            r5_side.last <= r4_last;

            r6_an   <= n6_an;
            r6_side <= r5_side;

            for (int k = 0; k < 3; k++) begin
                r7_sq[k] <= SQR_W'(r6_an[k]) * SQR_W'(r6_an[k]);
            end
            r7_an   <= r6_an;
            r7_side <= r6_side;

            r8_q    <= SQ_IN_W'(r7_sq[0]) + SQ_IN_W'(r7_sq[1]) + SQ_IN_W'(r7_sq[2]);
            r8_an   <= r7_an;
            r8_side <= r7_side;
        end
    end

    assign o_valid = r8_v;
    assign o_q     = r8_q;
    assign o_mag   = r8_an;
    assign o_side  = r8_side;

endmodule

### sv/rdg_sqrt.sv
// Pipelined digit-by-digit integer square root, two result bits per stage.
// Depends on rdg_pkg.
module rdg_sqrt import rdg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [SQ_IN_W-1:0] i_q,
    input  t_lanes             i_mag,
    input  t_side              i_side,
    output logic               o_valid,
    output logic [LEN_W-1:0]   o_len,
    output t_lanes             o_mag,
    output t_side              o_side
);

    localparam int ST = SQ_STAGES;

    logic                p_v    [ST];
    logic [SQ_REM_W-1:0] p_rem  [ST];
    logic [LEN_W-1:0]    p_root [ST];
    logic [SQ_IN_W-1:0]  p_q    [ST];
    t_lanes              p_mag  [ST];
    t_side               p_side [ST];

    logic [SQ_REM_W-1:0] n_rem  [ST];
    logic [LEN_W-1:0]    n_root [ST];
    logic [SQ_IN_W-1:0]  n_q    [ST];

    logic                r_v    [ST];
    logic [SQ_REM_W-1:0] r_rem  [ST];
    logic [LEN_W-1:0]    r_root [ST];
    logic [SQ_IN_W-1:0]  r_q    [ST];
    t_lanes              r_mag  [ST];
    t_side               r_side [ST];

    for (genvar g = 0; g < ST; g++) begin : g_st
        if (g == 0) begin : g_head
            assign p_v[g]    = i_valid;
            assign p_rem[g]  = '0;
            assign p_root[g] = '0;
            assign p_q[g]    = i_q;
            assign p_mag[g]  = i_mag;
            assign p_side[g] = i_side;
        end else begin : g_link
            assign p_v[g]    = r_v[g-1];
            assign p_rem[g]  = r_rem[g-1];
            assign p_root[g] = r_root[g-1];
            assign p_q[g]    = r_q[g-1];
            assign p_mag[g]  = r_mag[g-1];
            assign p_side[g] = r_side[g-1];
        end

        always_comb begin
            logic [SQ_REM_W-1:0] rem;
            logic [LEN_W-1:0]    root;
            logic [SQ_IN_W-1:0]  qs;
            logic [LEN_W+1:0]    trial;
            rem  = p_rem[g];
            root = p_root[g];
            qs   = p_q[g];
            for (int j = 0; j < 2; j++) begin
                rem   = {rem[SQ_REM_W-3:0], qs[SQ_IN_W-1 -: 2]};
                qs    = qs << 2;
                trial = {root, 2'b01};
                if (rem >= SQ_REM_W'(trial)) begin
                    rem  = rem - SQ_REM_W'(trial);
                    root = {root[LEN_W-2:0], 1'b1};
                end else begin
                    root = {root[LEN_W-2:0], 1'b0};
                end
            end
            n_rem[g]  = rem;
            n_root[g] = root;
            n_q[g]    = qs;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= p_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem[g];
                r_root[g] <= n_root[g];
                r_q[g]    <= n_q[g];
                r_mag[g]  <= p_mag[g];
                r_side[g] <= p_side[g];
            end
        end
    end

    assign o_valid = r_v[ST-1];
    assign o_len   = r_root[ST-1];
    assign o_mag   = r_mag[ST-1];
    assign o_side  = r_side[ST-1];

endmodule

### sv/rdg_div.sv
// Pipelined rounding divider: three lanes of magnitude * 2^DIR_FRAC_BITS / length.
// Depends on rdg_pkg.
module rdg_div import rdg_pkg::*; #(
    parameter int DIR_FRAC_BITS = DIR_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [LEN_W-1:0]                    i_len,
    input  t_lanes                              i_mag,
    input  t_side                               i_side,
    output logic                                o_valid,
    output logic [2:0][DIR_FRAC_BITS:0]         o_quo,
    output t_side                               o_side
);

    localparam int QW = DIR_FRAC_BITS + 1;
    localparam int NW = NORM_W + QW;
    localparam int ST = (QW + 1) / 2;

    typedef logic [2:0][DIV_REM_W-1:0] t_rem3;
    typedef logic [2:0][QW-1:0]        t_q3;

    logic [2:0][NW-1:0] num;

    logic             r0_v;
    t_rem3            r0_rem;
    t_q3              r0_low;
    logic [LEN_W-1:0] r0_len;
    t_side            r0_side;

    logic             p_v    [ST];
    t_rem3            p_rem  [ST];
    t_q3              p_low  [ST];
    t_q3              p_quo  [ST];
    logic [LEN_W-1:0] p_len  [ST];
    t_side            p_side [ST];

    t_rem3            n_rem  [ST];
    t_q3              n_low  [ST];
    t_q3              n_quo  [ST];

    logic             r_v    [ST];
    t_rem3            r_rem  [ST];
    t_q3              r_low  [ST];
    t_q3              r_quo  [ST];
    logic [LEN_W-1:0] r_len  [ST];
    t_side            r_side [ST];

    // Rounded numerator; the quotient never exceeds 2^DIR_FRAC_BITS, so the top part
    // of the numerator is already below the divisor.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            num[k] = (NW'(i_mag[k]) << DIR_FRAC_BITS) + NW'(i_len >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (i_en) begin
            r0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r0_rem[k] <= DIV_REM_W'(num[k][NW-1:QW]);
                r0_low[k] <= num[k][QW-1:0];
            end
            r0_len  <= i_len;
            r0_side <= i_side;
        end
    end

    for (genvar g = 0; g < ST; g++) begin : g_st
        if (g == 0) begin : g_head
            assign p_v[g]    = r0_v;
            assign p_rem[g]  = r0_rem;
            assign p_low[g]  = r0_low;
            assign p_quo[g]  = '0;
            assign p_len[g]  = r0_len;
            assign p_side[g] = r0_side;
        end else begin : g_link
            assign p_v[g]    = r_v[g-1];
            assign p_rem[g]  = r_rem[g-1];
            assign p_low[g]  = r_low[g-1];
            assign p_quo[g]  = r_quo[g-1];
            assign p_len[g]  = r_len[g-1];
            assign p_side[g] = r_side[g-1];
        end

        always_comb begin
            logic [DIV_REM_W-1:0] rem;
            logic [QW-1:0]        low;
            logic [QW-1:0]        quo;
            for (int k = 0; k < 3; k++) begin
                rem = p_rem[g][k];
                low = p_low[g][k];
                quo = p_quo[g][k];
                for (int j = 0; j < 2; j++) begin
                    if (g * 2 + j < QW) begin
                        rem = {rem[DIV_REM_W-2:0], low[QW-1]};
                        low = low << 1;
                        if (rem >= DIV_REM_W'(p_len[g])) begin
                            rem = rem - DIV_REM_W'(p_len[g]);
                            quo = {quo[QW-2:0], 1'b1};
                        end else begin
                            quo = {quo[QW-2:0], 1'b0};
                        end
                    end
                end
                n_rem[g][k] = rem;
                n_low[g][k] = low;
                n_quo[g][k] = quo;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= p_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem[g];
                r_low[g]  <= n_low[g];
                r_quo[g]  <= n_quo[g];
                r_len[g]  <= p_len[g];
                r_side[g] <= p_side[g];
            end
        end
    end

    assign o_valid = r_v[ST-1];
    assign o_quo   = r_quo[ST-1];
    assign o_side  = r_side[ST-1];

endmodule
